FILE: hw/rtl/ewg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ewg_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_WAVE_TYPE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BIAS        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_START_VALUE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT       = 3'd6;

    // waveform codes, anything else is a constant
    localparam logic [1:0] WAVE_CONST = 2'd0;
    localparam logic [1:0] WAVE_SINE  = 2'd1;
    localparam logic [1:0] WAVE_STEP  = 2'd2;

    localparam logic [14:0] LIMIT_RESET = 15'd10000;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [15:0] cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ewg_state_store.sv
`timescale 1ns / 1ps
`default_nettype none

module ewg_state_store #(
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [1];
    logic              mem_valid_reg;
    logic [DATA_W-1:0] rd_reg;
    logic              fwd_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[0] <= wr_data;
        end
        rd_reg       <= mem_valid_reg ? mem[0] : '0;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            if (wr_en) begin
                mem_valid_reg <= 1'b1;
            end
            fwd_reg <= wr_en;
        end
    end

    // the read register still holds the value from before the last write
    assign rd_data = fwd_reg ? fwd_data_reg : rd_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/excitation_waveform_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// One channel of a stimulus generator: every request is one sample tick and yields one
// command, a constant, sine or step around a bias, clamped to +/- limit, zero when disabled.
// A request is taken every cycle unless the result side stalls, which holds the whole pipe.
// The tick counter and phase accumulator live in a one-entry store read every cycle, with
// the previous request's write forwarded, so back to back ticks see each other's state.
// The store is valid-bit cleared, no clearing pass. Configuration must be written only
// while no request is in flight; the block itself does not enforce this.
module excitation_waveform_generator #(
    parameter int PHASE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int COUNT_BITS       = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [ewg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ewg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_restart,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output ewg_pkg::cmd_t                       m_command,
    output logic                                m_active
);

    localparam int FB     = PHASE_BITS - 2;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = FB + IDX_W + 1;
    localparam int CMP_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int ST_W   = COUNT_BITS + PHASE_BITS;
    localparam logic [PROD_W-1:0]     HALF_STEP = PROD_W'(1) << (FB - 1);
    localparam logic [IDX_W:0]        DEPTH_X   = (IDX_W + 1)'(SINE_TABLE_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [14:0] sine_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] sum;
        x    = (ewg_pkg::HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 12; k++) begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                10:      term = term / 64'd420;
                11:      term = term / 64'd506;
                default: term = term / 64'd600;
            endcase
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = ($unsigned(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    // 16-bit turn fraction onto the accumulator scale
    function automatic logic [PHASE_BITS-1:0] to_phase(input logic [15:0] v);
        logic [PHASE_BITS+15:0] t;
        t = {v, {PHASE_BITS{1'b0}}};
        return t[PHASE_BITS+15:16];
    endfunction

    // quarter-wave table
    logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];
    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [14:0] SINE_VAL = sine_entry(gi);
        assign sine_rom[gi] = SINE_VAL;
    end

    // configuration registers
    logic [1:0]         wave_type_reg;
    logic               enable_reg;
    logic signed [15:0] amplitude_reg;
    logic signed [15:0] bias_reg;
    logic [15:0]        phase_step_reg;
    logic [15:0]        start_value_reg;
    logic [14:0]        limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_type_reg   <= ewg_pkg::WAVE_CONST;
            enable_reg      <= 1'b0;
            amplitude_reg   <= '0;
            bias_reg        <= '0;
            phase_step_reg  <= '0;
            start_value_reg <= '0;
            limit_reg       <= ewg_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                ewg_pkg::REG_WAVE_TYPE:   wave_type_reg   <= cfg_wdata[1:0];
                ewg_pkg::REG_ENABLE:      enable_reg      <= cfg_wdata[0];
                ewg_pkg::REG_AMPLITUDE:   amplitude_reg   <= $signed(cfg_wdata);
                ewg_pkg::REG_BIAS:        bias_reg        <= $signed(cfg_wdata);
                ewg_pkg::REG_PHASE_STEP:  phase_step_reg  <= cfg_wdata;
                ewg_pkg::REG_START_VALUE: start_value_reg <= cfg_wdata;
                ewg_pkg::REG_LIMIT:       limit_reg       <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_restart_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // state store
    logic            st_we;
    logic [ST_W-1:0] st_wr_data;
    logic [ST_W-1:0] st_rd_data;

    ewg_state_store #(
        .DATA_W (ST_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (st_we),
        .wr_data (st_wr_data),
        .rd_data (st_rd_data)
    );

    // stage 1: state, phase, table lookup
    logic [COUNT_BITS-1:0] cur_elapsed;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [COUNT_BITS-1:0] next_elapsed;
    logic [PHASE_BITS-1:0] next_phase;
    logic [PHASE_BITS-1:0] sine_phase;
    logic [1:0]            quad;
    logic [PROD_W-1:0]     idx_sum;
    logic [IDX_W:0]        idx_raw;
    logic [IDX_W-1:0]      idx_clamped;
    logic [IDX_W-1:0]      idx;
    logic [14:0]           rom_val;
    logic signed [15:0]    sine_val;
    logic                  step_fire;

    always_comb begin
        cur_elapsed = s1_restart_reg ? '0 : st_rd_data[ST_W-1:PHASE_BITS];
        cur_phase   = s1_restart_reg ? '0 : st_rd_data[PHASE_BITS-1:0];
        next_elapsed = (cur_elapsed == COUNT_MAX) ? cur_elapsed
                                                  : cur_elapsed + COUNT_BITS'(1);
        next_phase   = cur_phase + to_phase(phase_step_reg);

        sine_phase = cur_phase + to_phase(start_value_reg);
        quad       = sine_phase[PHASE_BITS-1:PHASE_BITS-2];
        idx_sum    = PROD_W'(sine_phase[FB-1:0]) * PROD_W'(SINE_TABLE_DEPTH) + HALF_STEP;
        idx_raw    = idx_sum[PROD_W-1:FB];
        idx_clamped = (idx_raw > DEPTH_X) ? IDX_W'(SINE_TABLE_DEPTH) : idx_raw[IDX_W-1:0];
        // odd quadrants run the table backwards
        idx = quad[0] ? IDX_W'(SINE_TABLE_DEPTH) - idx_clamped : idx_clamped;
        rom_val  = sine_rom[idx];
        sine_val = quad[1] ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

        step_fire = CMP_W'(cur_elapsed) >= CMP_W'(start_value_reg);
    end

    assign st_we      = s1_valid_reg && adv;
    assign st_wr_data = {next_elapsed, next_phase};

    // stage registers
    logic signed [15:0] s2_sine_reg;
    logic               s2_fire_reg;
    logic signed [31:0] s3_prod_reg;
    logic               s3_fire_reg;
    ewg_pkg::cmd_t      out_command_reg;
    logic               out_active_reg;
    ewg_pkg::cmd_t      out_command_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= s_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_restart_reg  <= s_restart;
            s2_sine_reg     <= sine_val;
            s2_fire_reg     <= step_fire;
            s3_prod_reg     <= amplitude_reg * s2_sine_reg;
            s3_fire_reg     <= s2_fire_reg;
            out_command_reg <= out_command_next;
            out_active_reg  <= enable_reg;
        end
    end

    // stage 3: rounding, bias, clamp
    logic [31:0]        prod_round;
    logic signed [16:0] w_sine;
    logic signed [17:0] w_val;
    logic signed [17:0] v_sum;
    logic signed [17:0] lim_pos;

    always_comb begin
        prod_round = $unsigned(s3_prod_reg) + 32'd16384;
        w_sine     = $signed(prod_round[31:15]);
        case (wave_type_reg)
            ewg_pkg::WAVE_SINE: w_val = 18'(w_sine);
            ewg_pkg::WAVE_STEP: w_val = s3_fire_reg ? 18'(amplitude_reg) : '0;
            default:            w_val = 18'(amplitude_reg);
        endcase
        v_sum   = 18'(bias_reg) + w_val;
        lim_pos = $signed({3'b000, limit_reg});
        if (v_sum > lim_pos) begin
            v_sum = lim_pos;
        end
        if (v_sum < -lim_pos) begin
            v_sum = -lim_pos;
        end
        out_command_next = enable_reg ? v_sum[15:0] : '0;
    end

    assign m_valid   = out_valid_reg;
    assign m_command = out_command_reg;
    assign m_active  = out_active_reg;

`ifndef SYNTHESIS
    a_fwd_state: assert property (@(posedge aclk) disable iff (!aresetn)
        st_we |=> st_rd_data == $past(st_wr_data))
        else $error("state read does not see previous write");

    a_restart_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_we && s1_restart_reg) |-> st_wr_data[ST_W-1:PHASE_BITS] == COUNT_BITS'(1))
        else $error("restart did not clear the tick counter");

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_active) |-> m_command == '0)
        else $error("disabled channel drives a nonzero command");

    a_no_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_command != 16'sh8000)
        else $error("command outside symmetric range");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && !adv) |=> s3_valid_reg && $stable(s3_prod_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

FILE: test/excitation_waveform_generator_test.sv
`timescale 1ns / 1ps

module excitation_waveform_generator_test;

    localparam int SINE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_DIR = 21;
    localparam int RANDOM_TICKS = 1420;
    localparam logic [1:0] WAVE_UNUSED = 2'd3;
    localparam logic [14:0] LIM_MAX = 15'h7FFF;

    typedef struct packed {
        logic [1:0]         wave;
        logic               en;
        logic signed [15:0] amp;
        logic signed [15:0] bias;
        logic [15:0]        pstep;
        logic [15:0]        start;
        logic [14:0]        lim;
    } wave_cfg_t;

    typedef struct packed {
        ewg_pkg::cmd_t cmd;
        logic          act;
    } cmd_result_t;

    typedef struct packed {
        wave_cfg_t   cfg;
        logic        wr;
        logic        restart;
        logic        typed;
        cmd_result_t res;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [ewg_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [ewg_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic s_restart;
    logic m_valid;
    logic m_ready;
    ewg_pkg::cmd_t m_command;
    logic m_active;

    excitation_waveform_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_command (m_command),
        .m_active  (m_active)
    );

    // own copy of the generator: settings, tick counter, phase accumulator
    wave_cfg_t   cur;
    logic [15:0] elapsed_ticks;
    logic [15:0] phase_acc;
    logic [15:0] qsine [0:SINE_DEPTH];

    cmd_result_t pending_cmds [$];
    logic        typed_on;
    cmd_result_t typed_res;
    dir_row_t    dir_rows [N_DIR];

    int hold_req;
    int mismatches;
    int ticks_taken;
    int results_seen;
    int settings_loaded;
    int cycle_count;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_cmds.size());
            $display("tb: failure");
            $finish;
        end
    end

    // quarter-wave Q1.15 table from a Q30 Taylor series of the sine
    function automatic void build_quarter_sine();
        longint unsigned x, x2, term, r;
        longint          sum;
        int              i, k;
        for (i = 0; i <= SINE_DEPTH; i++) begin
            x = (ewg_pkg::HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (k = 1; k <= 12; k++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            r = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
            if (r > 64'd32767) r = 64'd32767;
            qsine[i] = 16'(r);
        end
    endfunction

    function automatic cmd_result_t predict_command(input logic restart);
        cmd_result_t res;
        logic [15:0] ph;
        logic [1:0]  quad;
        int          idx;
        longint      s, w, v, lim;
        if (restart) begin
            elapsed_ticks = '0;
            phase_acc = '0;
        end
        case (cur.wave)
            ewg_pkg::WAVE_SINE: begin
                ph = phase_acc + cur.start;
                quad = ph[15:14];
                idx = (int'(ph[13:0]) * SINE_DEPTH + 8192) >> 14;
                if (idx > SINE_DEPTH) idx = SINE_DEPTH;
                if (quad[0]) idx = SINE_DEPTH - idx;
                s = longint'(qsine[idx]);
                if (quad[1]) s = -s;
                // round half up, also on negative products
                w = (longint'($signed(cur.amp)) * s + 16384) >>> 15;
            end
            ewg_pkg::WAVE_STEP:
                w = (elapsed_ticks >= cur.start) ? longint'($signed(cur.amp)) : 0;
            default: w = longint'($signed(cur.amp));
        endcase
        lim = longint'(cur.lim);
        v = longint'($signed(cur.bias)) + w;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        if (!cur.en) v = 0;
        res.cmd = ewg_pkg::cmd_t'(v);
        res.act = cur.en;
        if (elapsed_ticks != 16'hFFFF) elapsed_ticks++;
        phase_acc = phase_acc + cur.pstep;
        return res;
    endfunction

    always @(posedge aclk) begin : scoreboard
        cmd_result_t predicted;
        cmd_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = predict_command(s_restart);
                pending_cmds.push_back(typed_on ? typed_res : predicted);
                ticks_taken++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_cmds.size() == 0) begin
                    if (mismatches < 10)
                        $display("result %0d with no request pending: command %0d active %0b",
                                 results_seen, m_command, m_active);
                    mismatches++;
                end else begin
                    want = pending_cmds.pop_front();
                    if (m_command !== want.cmd || m_active !== want.act) begin
                        if (mismatches < 10)
                            $display("result %0d: command %0d want %0d, active %0b want %0b",
                                     results_seen, m_command, $signed(want.cmd),
                                     m_active, want.act);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side: stall patterns that change every so often, plus requested hold-offs
    initial begin : result_sink
        int mode;
        int span;
        int hold_left;
        mode = 0;
        span = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 150);
            end
            span--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) < 7);
                    2: m_ready <= (span % 3 != 0);
                    default: m_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    task automatic put_reg(input logic [ewg_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [15:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
    endtask

    // only called with nothing in flight
    task automatic load_settings(input wave_cfg_t c);
        put_reg(ewg_pkg::REG_WAVE_TYPE, 16'(c.wave));
        put_reg(ewg_pkg::REG_ENABLE, 16'(c.en));
        put_reg(ewg_pkg::REG_AMPLITUDE, c.amp);
        put_reg(ewg_pkg::REG_BIAS, c.bias);
        put_reg(ewg_pkg::REG_PHASE_STEP, c.pstep);
        put_reg(ewg_pkg::REG_START_VALUE, c.start);
        put_reg(ewg_pkg::REG_LIMIT, {1'b0, c.lim});
        @(negedge aclk);
        cfg_we <= 1'b0;
        cur = c;
        settings_loaded++;
    endtask

    task automatic send_ticks(input int n, input int restart_pct, input bit gaps);
        int burst;
        int gap;
        int i;
        burst = $urandom_range(1, 24);
        for (i = 0; i < n; i++) begin
            if (gaps && burst == 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                gap = $urandom_range(1, 8);
                repeat (gap) @(posedge aclk);
                burst = $urandom_range(1, 24);
            end
            @(negedge aclk);
            s_valid <= 1'b1;
            s_restart <= ($urandom_range(0, 99) < restart_pct);
            do @(posedge aclk); while (!s_ready);
            burst--;
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wave_cfg_t pick_settings(input int n);
        wave_cfg_t c;
        int        sel;
        sel = $urandom_range(0, 9);
        c.wave = (sel < 3) ? ewg_pkg::WAVE_CONST : (sel < 6) ? ewg_pkg::WAVE_SINE :
                 (sel < 9) ? ewg_pkg::WAVE_STEP : WAVE_UNUSED;
        c.en = ($urandom_range(0, 7) != 0);
        c.amp = pick_word();
        c.bias = ($urandom_range(0, 1) == 0) ? pick_word()
                                             : 16'($urandom_range(0, 4000)) - 16'd2000;
        c.pstep = ($urandom_range(0, 2) == 0) ? pick_word() : 16'($urandom_range(0, 3000));
        // step times mostly land inside the run so the step is seen firing
        if (c.wave == ewg_pkg::WAVE_STEP && $urandom_range(0, 3) != 0)
            c.start = 16'($urandom_range(0, n));
        else
            c.start = pick_word();
        case ($urandom_range(0, 5))
            0: c.lim = 15'd0;
            1: c.lim = LIM_MAX;
            2: c.lim = 15'($urandom_range(1, 300));
            default: c.lim = 15'($urandom);
        endcase
        return c;
    endfunction

    initial begin : stimulus
        wave_cfg_t sine_cfg;
        wave_cfg_t sine_wrap_cfg;
        wave_cfg_t step_cfg;
        wave_cfg_t c;
        int        i;
        int        n;
        int        phase_no;
        int        random_ticks;

        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= ewg_pkg::REG_WAVE_TYPE;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_restart <= 1'b0;
        hold_req = 0;
        typed_on = 1'b0;
        typed_res = '0;
        mismatches = 0;
        ticks_taken = 0;
        results_seen = 0;
        settings_loaded = 0;
        cycle_count = 0;
        random_ticks = 0;

        build_quarter_sine();
        cur = '{ewg_pkg::WAVE_CONST, 1'b0, 16'sd0, 16'sd0, 16'd0, 16'd0,
                ewg_pkg::LIMIT_RESET};
        elapsed_ticks = '0;
        phase_acc = '0;

        sine_cfg      = '{ewg_pkg::WAVE_SINE, 1'b1, 16'sd32767, 16'sd0, 16'd16384, 16'd0,
                          LIM_MAX};
        sine_wrap_cfg = '{ewg_pkg::WAVE_SINE, 1'b1, 16'sh8000, 16'sd100, 16'hFFFF, 16'hFFFF,
                          LIM_MAX};
        step_cfg      = '{ewg_pkg::WAVE_STEP, 1'b1, 16'sd500, -16'sd100, 16'd0, 16'd2,
                          15'd10000};

        // settings, write, restart, typed, expected
        dir_rows[0]  = '{cur, 1'b0, 1'b0, 1'b1, '{16'sd0, 1'b0}};
        dir_rows[1]  = '{'{ewg_pkg::WAVE_CONST, 1'b1, 16'sd100, 16'sd0, 16'd0, 16'd0,
                           15'd10000},
                         1'b1, 1'b0, 1'b1, '{16'sd100, 1'b1}};
        dir_rows[2]  = '{'{ewg_pkg::WAVE_CONST, 1'b1, 16'sd32767, 16'sd32767, 16'd0, 16'd0,
                           LIM_MAX},
                         1'b1, 1'b1, 1'b1, '{16'sd32767, 1'b1}};
        dir_rows[3]  = '{'{ewg_pkg::WAVE_CONST, 1'b1, 16'sh8000, 16'sh8000, 16'd0, 16'd0,
                           LIM_MAX},
                         1'b1, 1'b0, 1'b1, '{-16'sd32767, 1'b1}};
        dir_rows[4]  = '{'{ewg_pkg::WAVE_CONST, 1'b1, 16'sh8000, 16'sd0, 16'd0, 16'd0, 15'd0},
                         1'b1, 1'b0, 1'b1, '{16'sd0, 1'b1}};
        dir_rows[5]  = '{'{WAVE_UNUSED, 1'b1, 16'sd1234, -16'sd34, 16'd0, 16'd0, LIM_MAX},
                         1'b1, 1'b0, 1'b1, '{16'sd1200, 1'b1}};
        dir_rows[6]  = '{'{ewg_pkg::WAVE_CONST, 1'b0, 16'sd5000, 16'sd0, 16'd0, 16'd0,
                           LIM_MAX},
                         1'b1, 1'b0, 1'b1, '{16'sd0, 1'b0}};
        // quarter-turn steps walk all four quadrants
        dir_rows[7]  = '{sine_cfg, 1'b1, 1'b1, 1'b1, '{16'sd0, 1'b1}};
        dir_rows[8]  = '{sine_cfg, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[9]  = '{sine_cfg, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[10] = '{sine_cfg, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[11] = '{sine_wrap_cfg, 1'b1, 1'b1, 1'b0, '0};
        dir_rows[12] = '{sine_wrap_cfg, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[13] = '{'{ewg_pkg::WAVE_SINE, 1'b1, 16'sd20000, -16'sd500, 16'd1, 16'd8191,
                           15'd1000},
                         1'b1, 1'b1, 1'b0, '0};
        dir_rows[14] = '{'{ewg_pkg::WAVE_STEP, 1'b1, 16'sd500, -16'sd100, 16'd0, 16'd0,
                           15'd10000},
                         1'b1, 1'b1, 1'b1, '{16'sd400, 1'b1}};
        dir_rows[15] = '{step_cfg, 1'b1, 1'b1, 1'b1, '{-16'sd100, 1'b1}};
        dir_rows[16] = '{step_cfg, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[17] = '{step_cfg, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[18] = '{'{ewg_pkg::WAVE_STEP, 1'b0, 16'sd500, -16'sd100, 16'd0, 16'd0,
                           15'd10000},
                         1'b1, 1'b0, 1'b1, '{16'sd0, 1'b0}};
        dir_rows[19] = '{'{ewg_pkg::WAVE_CONST, 1'b1, 16'sd0, 16'sh8000, 16'd0, 16'd0,
                           LIM_MAX},
                         1'b1, 1'b0, 1'b1, '{-16'sd32767, 1'b1}};
        dir_rows[20] = '{'{ewg_pkg::WAVE_CONST, 1'b1, 16'sd32767, 16'sd1, 16'd0, 16'd0,
                           LIM_MAX},
                         1'b1, 1'b0, 1'b1, '{16'sd32767, 1'b1}};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            if (dir_rows[i].wr) load_settings(dir_rows[i].cfg);
            typed_on = dir_rows[i].typed;
            typed_res = dir_rows[i].res;
            send_ticks(1, dir_rows[i].restart ? 100 : 0, 1'b0);
            wait_drained();
            typed_on = 1'b0;
        end

        phase_no = 0;
        while (random_ticks < RANDOM_TICKS) begin
            n = $urandom_range(20, 70);
            c = pick_settings(n);
            load_settings(c);
            if (phase_no == 4) begin
                // long result-side hold-off while requests keep coming
                hold_req = 400;
                n = 120;
                send_ticks(n, 3, 1'b0);
            end else begin
                send_ticks(1, 50, 1'b0);
                send_ticks(n - 1, $urandom_range(0, 15), ($urandom_range(0, 3) != 0));
            end
            wait_drained();
            random_ticks += n;
            phase_no++;
        end

        repeat (16) @(posedge aclk);
        $display("covered %0d ticks (%0d random) over %0d register settings, all wave types",
                 ticks_taken, random_ticks, settings_loaded);
        $display("and a long output hold-off; %0d results checked, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: excitation_waveform_generator.f
hw/rtl/ewg_pkg.sv
hw/rtl/ewg_state_store.sv
hw/rtl/excitation_waveform_generator.sv
test/excitation_waveform_generator_test.sv
